FILE: sv/touch_key_baseline_scanner_unit_defines.svh
// ----------------------------------------------------------------------------
// touch_key_baseline_scanner_unit_defines
// Assertion macros used by the touch key scanner core.
// ----------------------------------------------------------------------------
`ifndef TOUCH_KEY_BASELINE_SCANNER_UNIT_DEFINES_SVH
`define TOUCH_KEY_BASELINE_SCANNER_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is low
`define TKBS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define TKBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/tkbs_pkg.sv
// ----------------------------------------------------------------------------
// tkbs_pkg
// Types, constants and helpers for the touch key baseline scanner.
// ----------------------------------------------------------------------------
package tkbs_pkg;

    // Field widths
    localparam int SAMPLE_W = 14;
    localparam int THR_W    = 14;
    localparam int CODES_W  = 12;
    localparam int CODE_W   = 3;
    localparam int STATE_W  = 8;
    localparam int ACC_W    = 16;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES     = 2'd1;

    // Register reset values (codes 4,3,5,6 from slot zero up)
    localparam logic [THR_W-1:0]   THR_RESET   = 14'd100;
    localparam logic [CODES_W-1:0] CODES_RESET = 12'd3420;
    localparam logic [STATE_W-1:0] STATE_RESET = 8'hFF;

    // Valid touch code range
    localparam logic [CODE_W-1:0] CODE_MIN = 3'd1;
    localparam logic [CODE_W-1:0] CODE_MAX = 3'd6;

    // One result item
    typedef struct packed {
        logic [CODE_W-1:0]  next_code;
        logic [STATE_W-1:0] touch_bits;
        logic               calibrating;
    } t_result;

    // Input code of a slot; slots four and up have no channel
    function automatic logic [CODE_W-1:0] code_of(input logic [2:0] slot,
                                                  input logic [CODES_W-1:0] codes);
        logic [CODE_W-1:0] code;
        case (slot)
            3'd0:    code = codes[2:0];
            3'd1:    code = codes[5:3];
            3'd2:    code = codes[8:6];
            3'd3:    code = codes[11:9];
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

FILE: sv/tkbs_recip_div.sv
// ----------------------------------------------------------------------------
// tkbs_recip_div
// Divides the 16-bit calibration sum by SAMPLES with a reciprocal multiply.
// ----------------------------------------------------------------------------
module tkbs_recip_div #(
    parameter int SAMPLES = 4
) (
    input  logic [tkbs_pkg::ACC_W-1:0]    i_dividend,
    output logic [tkbs_pkg::SAMPLE_W-1:0] o_quotient
);

    // ceil(2^(16+5)/d) is exact for every 16-bit dividend and d up to 32
    localparam int DIV_SHIFT = tkbs_pkg::ACC_W + 5;
    localparam int DIV_MUL_W = DIV_SHIFT + 1;
    localparam int PROD_W    = tkbs_pkg::ACC_W + DIV_MUL_W;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL =
        DIV_MUL_W'(((longint'(1) << DIV_SHIFT) + SAMPLES - 1) / SAMPLES);

    logic [PROD_W-1:0] product;

    assign product    = PROD_W'(i_dividend) * PROD_W'(DIV_MUL);
    // quotient keeps its low 14 bits
    assign o_quotient = product[DIV_SHIFT +: tkbs_pkg::SAMPLE_W];

endmodule

FILE: sv/tkbs_core.sv
// ----------------------------------------------------------------------------
// tkbs_core
// Calibration and scan state; computes the update for one sample.
// ----------------------------------------------------------------------------
`include "touch_key_baseline_scanner_unit_defines.svh"

module tkbs_core #(
    parameter int CHANNELS = 4,
    parameter int SAMPLES  = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [tkbs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [tkbs_pkg::THR_W-1:0]    i_threshold,
    input  logic [tkbs_pkg::CODES_W-1:0]  i_codes,
    output tkbs_pkg::t_result             o_result
);

    localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHANNELS - 1);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(SAMPLES - 1);

    logic [tkbs_pkg::SAMPLE_W-1:0] r_baseline [CHANNELS];
    logic [tkbs_pkg::STATE_W-1:0]  r_touch_state, n_touch_state;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic [tkbs_pkg::ACC_W-1:0]    r_acc, n_acc;
    logic                          r_in_cal, n_in_cal;

    logic [tkbs_pkg::ACC_W-1:0]    acc_sum;
    logic [tkbs_pkg::SAMPLE_W-1:0] quotient;
    logic                          base_we;
    logic [tkbs_pkg::CODE_W-1:0]   code;
    logic [tkbs_pkg::CODE_W-1:0]   bit_idx;
    logic                          touched;

    // Sum wraps at 16 bits
    assign acc_sum = r_acc + tkbs_pkg::ACC_W'(i_sample);

    tkbs_recip_div #(
        .SAMPLES (SAMPLES)
    ) u_div (
        .i_dividend (acc_sum),
        .o_quotient (quotient)
    );

    // Threshold compare without wrap
    assign touched = ({1'b0, i_sample} + {1'b0, i_threshold}) < {1'b0, r_baseline[r_slot]};
    assign code    = tkbs_pkg::code_of(3'(r_slot), i_codes);
    assign bit_idx = code - 3'd1;

    // Next state
    always_comb begin
        n_touch_state = r_touch_state;
        n_slot        = r_slot;
        n_cnt         = r_cnt;
        n_acc         = r_acc;
        n_in_cal      = r_in_cal;
        base_we       = 1'b0;
        if (r_in_cal) begin
            if (r_cnt == LAST_CNT) begin
                base_we = 1'b1;
                n_acc   = '0;
                n_cnt   = '0;
                if (r_slot == LAST_SLOT) begin
                    n_in_cal = 1'b0;
                    n_slot   = '0;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end else begin
                n_acc = acc_sum;
                n_cnt = r_cnt + 1'b1;
            end
        end else begin
            if (code inside {[tkbs_pkg::CODE_MIN:tkbs_pkg::CODE_MAX]}) begin
                n_touch_state[bit_idx] = ~touched;
            end
            n_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
        end
    end

    // Result reflects the state after this sample
    assign o_result.next_code   = tkbs_pkg::code_of(3'(n_slot), i_codes);
    assign o_result.touch_bits  = n_touch_state;
    assign o_result.calibrating = n_in_cal;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_state <= tkbs_pkg::STATE_RESET;
            r_slot        <= '0;
            r_cnt         <= '0;
            r_acc         <= '0;
            r_in_cal      <= 1'b1;
        end else if (i_step) begin
            r_touch_state <= n_touch_state;
            r_slot        <= n_slot;
            r_cnt         <= n_cnt;
            r_acc         <= n_acc;
            r_in_cal      <= n_in_cal;
        end
    end

    // Baselines, written once each during calibration
    always_ff @(posedge i_clk) begin
        if (i_step && base_we) begin
            r_baseline[r_slot] <= quotient;
        end
    end

    // Assertions
    `TKBS_ASSERT_CLK(a_cal_holds_state, i_clk, i_rst_n,
        r_in_cal && i_step |=> r_touch_state == $past(r_touch_state),
        "touch state changed during calibration")
    `TKBS_ASSERT_CLK(a_cal_no_restart, i_clk, i_rst_n,
        !r_in_cal |=> !r_in_cal, "calibration restarted without reset")
    `TKBS_ASSERT_CLK(a_scan_idle_acc, i_clk, i_rst_n,
        !r_in_cal |-> (r_cnt == '0 && r_acc == '0),
        "accumulator not cleared after calibration")
    `TKBS_ASSERT_CLK(a_slot_range, i_clk, i_rst_n,
        r_slot <= LAST_SLOT && r_touch_state[7:6] == 2'b11,
        "slot out of range or upper touch bits cleared")
    `TKBS_ASSERT_ALWAYS(a_reset_state, i_clk,
        !i_rst_n |=> (r_in_cal && r_slot == '0 && r_touch_state == tkbs_pkg::STATE_RESET),
        "state not restored by reset")

endmodule

FILE: sv/touch_key_baseline_scanner_unit.sv
// Path: a sample accepted into the input register is processed and its result captured in the
// result register. Throughput: one sample per cycle while the result register is free or drained;
// the state update (accumulate, reciprocal divide, threshold compare) is combinational between them.
// Input stays ready while a result waits, as long as the input register can move on.
// Reset (i_rst_n low, synchronous): both stages empty, registers to defaults,
// touch bits all ones, calibration restarts at slot zero.
// ----------------------------------------------------------------------------
// touch_key_baseline_scanner_unit
// Capacitive touch key scanner with baseline calibration and round-robin scan.
// ----------------------------------------------------------------------------
module touch_key_baseline_scanner_unit #(
    parameter int CHANNELS = 4,
    parameter int SAMPLES  = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [tkbs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tkbs_pkg::CFG_W-1:0]     i_cfg_data,
    // sample channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [tkbs_pkg::SAMPLE_W-1:0]  i_sample,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [tkbs_pkg::CODE_W-1:0]    o_next_code,
    output logic [tkbs_pkg::STATE_W-1:0]   o_touch_bits,
    output logic                           o_calibrating
);

    logic [tkbs_pkg::THR_W-1:0]    r_threshold;
    logic [tkbs_pkg::CODES_W-1:0]  r_codes;
    logic                          r_s1_valid;
    logic [tkbs_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                          r_out_valid;
    tkbs_pkg::t_result             r_out;
    tkbs_pkg::t_result             core_result;
    logic                          advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= tkbs_pkg::THR_RESET;
            r_codes     <= tkbs_pkg::CODES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tkbs_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[tkbs_pkg::THR_W-1:0];
                tkbs_pkg::CFG_CODES:     r_codes     <= i_cfg_data[tkbs_pkg::CODES_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage moves when the result register is free or being drained
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_sample <= i_sample;
        end
    end

    tkbs_core #(
        .CHANNELS (CHANNELS),
        .SAMPLES  (SAMPLES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_sample    (r_s1_sample),
        .i_threshold (r_threshold),
        .i_codes     (r_codes),
        .o_result    (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_code   = r_out.next_code;
    assign o_touch_bits  = r_out.touch_bits;
    assign o_calibrating = r_out.calibrating;

endmodule
